// ===== src/cscan_pkg.sv =====
`default_nettype none
package cscan_pkg;

   localparam int unsigned MaxRequestsDefault = 32;
   localparam int unsigned CylW  = 16;
   localparam int unsigned KindW = 2;
   localparam int unsigned SeekW = 18;
   localparam logic [SeekW-1:0] SeekMax = {SeekW{1'b1}};
   localparam logic [CylW-1:0] TopReset = 16'd199;
   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned CsrRegBit = 2;

   localparam logic [0:0] REG_HEAD = 1'b0;
   localparam logic [0:0] REG_TOP  = 1'b1;

   typedef enum logic [KindW-1:0] {
      KIND_SERVED = 2'd0,
      KIND_TOP    = 2'd1,
      KIND_ZERO   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_A_RD,
      ST_A_USE,
      ST_TOP,
      ST_ZERO,
      ST_B_RD,
      ST_B_USE
   } state_type;

   typedef struct packed {
      logic            init;
      logic            step;
      logic            ret;
      logic [CylW-1:0] target;
   } seek_cmd_type;

endpackage
`default_nettype wire

// ===== src/cscan_ifs.sv =====
`default_nettype none
interface cscan_req_if import cscan_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CylW-1:0] request_cylinder;
   logic            final_request;
   modport source(output valid, request_cylinder, final_request, input ready);
   modport sink(input valid, request_cylinder, final_request, output ready);
endinterface

interface cscan_rsp_if import cscan_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CylW-1:0]  visited_cylinder;
   logic [KindW-1:0] position_kind;
   logic [SeekW-1:0] running_seek;
   logic             last_of_run;
   modport source(output valid, visited_cylinder, position_kind, running_seek, last_of_run,
                  input ready);
   modport sink(input valid, visited_cylinder, position_kind, running_seek, last_of_run,
                output ready);
endinterface
`default_nettype wire

// ===== src/cscan_store.sv =====
`default_nettype none
module cscan_store import cscan_pkg::*; #(
   parameter int unsigned Depth = MaxRequestsDefault,
   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire logic [CylW-1:0] wr_data,
   input  wire logic            rd_en,
   input  wire logic [AW-1:0]   rd_addr,
   output logic [CylW-1:0]      rd_data
);

   logic [CylW-1:0] store_mem [Depth];
   logic [CylW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/cscan_seek.sv =====
`default_nettype none
module cscan_seek import cscan_pkg::*; (
   input  wire logic            clock,
   input  wire seek_cmd_type    cmd,
   input  wire logic [CylW-1:0] head,
   input  wire logic [CylW-1:0] top,
   output logic [SeekW-1:0]     seek_next,
   output logic [CylW-1:0]      cur_pos
);

   logic [CylW-1:0]  cur_ff, cur_in;
   logic [SeekW-1:0] seek_ff, seek_in;
   logic [CylW-1:0]  move_dist;
   logic [CylW-1:0]  add;
   logic [SeekW:0]   sum;

   // distance of this move; the return stroke counts the full top cylinder
   always_comb begin
      move_dist = (cmd.target > cur_ff) ? (cmd.target - cur_ff) : (cur_ff - cmd.target);
      add  = cmd.ret ? top : move_dist;
      sum  = {1'b0, seek_ff} + {{(SeekW + 1 - CylW){1'b0}}, add};
      seek_next = (sum > {1'b0, SeekMax}) ? SeekMax : sum[SeekW-1:0];
   end

   // start a run at the head, or advance on each move
   always_comb begin
      cur_in  = cur_ff;
      seek_in = seek_ff;
      if (cmd.init) begin
         cur_in  = head;
         seek_in = '0;
      end else if (cmd.step) begin
         cur_in  = cmd.ret ? '0 : cmd.target;
         seek_in = seek_next;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      seek_ff <= seek_in;
   end

   assign cur_pos = cur_ff;

endmodule
`default_nettype wire

// ===== src/cscan_disk_scheduler_top.sv =====
// C-SCAN disk scheduler.
// req channel: one cylinder request per transaction; final_request marks the
// last request of a batch. Requests are insertion-sorted into a one-port-read
// memory: after the accept cycle each insert walks down from the end, reading
// and comparing one entry at a time and moving larger ones up one place, then
// writes the new request where it stops. req.ready is high only while idle.
// After the final request the schedule drains on the rsp channel: a first
// pass over the memory serves requests at or above the head, then the top
// cylinder (skipped if already there), then cylinder zero, then a second
// pass serves the requests below the head.
// Each rsp transaction carries the cylinder, its kind, the saturating running
// seek total and last_of_run on the final move. The output register holds a
// result until taken; a stalled receiver simply pauses the drain.
// Up to MaxRequests requests are kept; further ones are dropped.
// csr port: head_position at 0x0, top_cylinder at 0x4; write only while idle.
// Reset (synchronous) empties the list, sets head 0 and top 199; no clearing
// pass is needed, the memory is read only below the stored count.
`default_nettype none
module cscan_disk_scheduler_top import cscan_pkg::*; #(
   parameter int unsigned MaxRequests = MaxRequestsDefault,
   localparam int unsigned CW = $clog2(MaxRequests + 1),
   localparam int unsigned AW = (MaxRequests > 1) ? $clog2(MaxRequests) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   cscan_req_if.sink                req,
   cscan_rsp_if.source              rsp,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0]      csr_prdata,
   output logic                     csr_pready
);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    nbelow_ff, nbelow_in;
   logic [CylW-1:0]  value_ff, value_in;
   logic             final_ff, final_in;
   logic [CylW-1:0]  head_ff, top_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [CylW-1:0]  rsp_cyl_ff, rsp_cyl_in;
   logic [KindW-1:0] rsp_kind_ff, rsp_kind_in;
   logic [SeekW-1:0] rsp_seek_ff, rsp_seek_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             wr_en, rd_en;
   logic [CW-1:0]    wr_addr_full, rd_addr_full;
   logic [CylW-1:0]  wr_data, rd_data;
   seek_cmd_type     seek_cmd;
   logic [SeekW-1:0] seek_next;
   logic [CylW-1:0]  cur_pos;

   logic slot, full, accept, csr_write;

   assign slot      = !rsp_valid_ff || rsp.ready;
   assign full      = (count_ff == CW'(MaxRequests));
   assign accept    = req.valid && req.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   cscan_store #(.Depth(MaxRequests)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_full[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_full[AW-1:0]),
      .rd_data (rd_data)
   );

   cscan_seek u_seek (
      .clock     (clock),
      .cmd       (seek_cmd),
      .head      (head_ff),
      .top       (top_ff),
      .seek_next (seek_next),
      .cur_pos   (cur_pos)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         top_ff  <= TopReset;
      end else if (csr_write) begin
         if (csr_paddr[CsrRegBit] == REG_TOP) begin
            top_ff <= csr_pwdata[CylW-1:0];
         end else begin
            head_ff <= csr_pwdata[CylW-1:0];
         end
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CsrDataW - CylW){1'b0}},
                        (csr_paddr[CsrRegBit] == REG_TOP) ? top_ff : head_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (!full) begin
                  state_in = ST_INS_RD;
               end else if (req.final_request) begin
                  state_in = ST_A_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               state_in = final_ff ? ST_A_RD : ST_IDLE;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (rd_data > value_ff) begin
               state_in = ST_INS_RD;
            end else begin
               state_in = final_ff ? ST_A_RD : ST_IDLE;
            end
         end
         ST_A_RD:  state_in = (idx_ff == count_ff) ? ST_TOP : ST_A_USE;
         ST_A_USE: begin
            if (rd_data < head_ff || slot) begin
               state_in = ST_A_RD;
            end
         end
         ST_TOP: begin
            if (cur_pos == top_ff || slot) begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (slot) begin
               state_in = (nbelow_ff == '0) ? ST_IDLE : ST_B_RD;
            end
         end
         ST_B_RD:  state_in = ST_B_USE;
         ST_B_USE: begin
            if (slot) begin
               state_in = (idx_ff == nbelow_ff - CW'(1)) ? ST_IDLE : ST_B_RD;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);

   // datapath: memory accesses, counters and result loading
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      nbelow_in    = nbelow_ff;
      value_in     = value_ff;
      final_in     = final_ff;
      wr_en        = 1'b0;
      wr_addr_full = idx_ff;
      wr_data      = value_ff;
      rd_en        = 1'b0;
      rd_addr_full = idx_ff;
      seek_cmd     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_cyl_in   = rsp_cyl_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req.request_cylinder;
               final_in = req.final_request;
               idx_in   = count_ff;
               if (full) begin
                  idx_in        = '0;
                  nbelow_in     = '0;
                  seek_cmd.init = 1'b1;
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               if (final_ff) begin
                  idx_in        = '0;
                  nbelow_in     = '0;
                  seek_cmd.init = 1'b1;
               end
            end else begin
               rd_en        = 1'b1;
               rd_addr_full = idx_ff - CW'(1);
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (rd_data > value_ff) begin
               // move the larger entry up one place
               wr_data = rd_data;
               idx_in  = idx_ff - CW'(1);
            end else begin
               count_in = count_ff + CW'(1);
               if (final_ff) begin
                  idx_in        = '0;
                  nbelow_in     = '0;
                  seek_cmd.init = 1'b1;
               end
            end
         end
         ST_A_RD: begin
            rd_en = (idx_ff != count_ff);
         end
         ST_A_USE: begin
            if (rd_data < head_ff) begin
               nbelow_in = nbelow_ff + CW'(1);
               idx_in    = idx_ff + CW'(1);
            end else if (slot) begin
               seek_cmd.step   = 1'b1;
               seek_cmd.target = rd_data;
               rsp_valid_in    = 1'b1;
               rsp_cyl_in      = rd_data;
               rsp_kind_in     = KIND_SERVED;
               rsp_seek_in     = seek_next;
               rsp_last_in     = 1'b0;
               idx_in          = idx_ff + CW'(1);
            end
         end
         ST_TOP: begin
            if (cur_pos != top_ff && slot) begin
               seek_cmd.step   = 1'b1;
               seek_cmd.target = top_ff;
               rsp_valid_in    = 1'b1;
               rsp_cyl_in      = top_ff;
               rsp_kind_in     = KIND_TOP;
               rsp_seek_in     = seek_next;
               rsp_last_in     = 1'b0;
            end
         end
         ST_ZERO: begin
            if (slot) begin
               seek_cmd.step = 1'b1;
               seek_cmd.ret  = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_cyl_in    = '0;
               rsp_kind_in   = KIND_ZERO;
               rsp_seek_in   = seek_next;
               rsp_last_in   = (nbelow_ff == '0);
               idx_in        = '0;
               if (nbelow_ff == '0) begin
                  count_in = '0;
               end
            end
         end
         ST_B_RD: begin
            rd_en = 1'b1;
         end
         ST_B_USE: begin
            if (slot) begin
               seek_cmd.step   = 1'b1;
               seek_cmd.target = rd_data;
               rsp_valid_in    = 1'b1;
               rsp_cyl_in      = rd_data;
               rsp_kind_in     = KIND_SERVED;
               rsp_seek_in     = seek_next;
               rsp_last_in     = (idx_ff == nbelow_ff - CW'(1));
               idx_in          = idx_ff + CW'(1);
               if (idx_ff == nbelow_ff - CW'(1)) begin
                  count_in = '0;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp.ready;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      nbelow_ff   <= nbelow_in;
      value_ff    <= value_in;
      final_ff    <= final_in;
      rsp_cyl_ff  <= rsp_cyl_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_seek_ff <= rsp_seek_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.visited_cylinder = rsp_cyl_ff;
   assign rsp.position_kind    = rsp_kind_ff;
   assign rsp.running_seek     = rsp_seek_ff;
   assign rsp.last_of_run      = rsp_last_ff;

   // the list never grows past its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MaxRequests))
      else $error("request count above capacity");

   // the second pass only walks entries counted below the head
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_USE) |-> (nbelow_ff != '0 && idx_ff < nbelow_ff))
      else $error("second pass index out of range");

   // a pass entry is used only after its memory read was issued
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_USE) |->
         ($past(state_ff) == ST_A_RD || $past(state_ff) == ST_A_USE))
      else $error("first pass used data without a read");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
   import cscan_pkg::*;

   typedef struct packed {
      logic [CylW-1:0]  cyl;
      kind_type         kind;
      logic [SeekW-1:0] seek;
      logic             last;
   } move_type;

   localparam int unsigned MaxReq = MaxRequestsDefault;
   localparam int unsigned LimitCycles = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [CsrDataW-1:0] csr_pwdata = '0;
   logic [CsrDataW-1:0] csr_prdata;
   logic csr_pready;

   cscan_req_if req ();
   cscan_rsp_if rsp ();

   cscan_disk_scheduler_top uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // scheduler state mirrored on the testbench side
   logic [CylW-1:0] head_pos;
   logic [CylW-1:0] top_cyl;
   logic [CylW-1:0] pending[$];
   move_type expected_moves[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int cycles = 0;
   int moves_seen = 0;

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.request_cylinder = '0;
      req.final_request = 1'b0;
      rsp.ready = 1'b0;
   end

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LimitCycles) begin
         $display("status: fail");
         $finish;
      end
   end

   // randomize backpressure on the result side
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each result transaction against the oldest expected move
   always @(posedge clock) begin
      move_type exp_m;
      if (!reset && rsp.valid && rsp.ready) begin
         moves_seen <= moves_seen + 1;
         if (expected_moves.size() == 0) begin
            $display("%0t unexpected move cyl=%0d kind=%0d seek=%0d last=%0b", $time,
                     rsp.visited_cylinder, rsp.position_kind, rsp.running_seek,
                     rsp.last_of_run);
            errors++;
         end else begin
            exp_m = expected_moves.pop_front();
            if (rsp.visited_cylinder !== exp_m.cyl || rsp.position_kind !== exp_m.kind ||
                rsp.running_seek !== exp_m.seek || rsp.last_of_run !== exp_m.last) begin
               $display("%0t mismatch exp cyl=%0d kind=%0d seek=%0d last=%0b", $time,
                        exp_m.cyl, exp_m.kind, exp_m.seek, exp_m.last);
               $display("%0t          got cyl=%0d kind=%0d seek=%0d last=%0b", $time,
                        rsp.visited_cylinder, rsp.position_kind, rsp.running_seek,
                        rsp.last_of_run);
               errors++;
            end
         end
      end
   end

   // append one head movement, accumulating the saturating seek total
   function automatic void add_move(input logic [CylW-1:0] cyl, input kind_type kind,
                                    input int unsigned step_dist, inout int unsigned seek,
                                    inout logic [CylW-1:0] pos);
      move_type m;
      seek = seek + step_dist;
      if (seek > SeekMax) seek = SeekMax;
      pos = cyl;
      m.cyl = cyl;
      m.kind = kind;
      m.seek = seek[SeekW-1:0];
      m.last = 1'b0;
      expected_moves.push_back(m);
   endfunction

   function automatic int unsigned abs_diff(input logic [CylW-1:0] a, input logic [CylW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // store one request in order; on the final one, plan the whole C-SCAN sweep
   function automatic void plan_sweep(input logic [CylW-1:0] cyl, input logic fin);
      int idx;
      int split;
      int unsigned seek;
      logic [CylW-1:0] pos;
      move_type m;
      if (pending.size() < MaxReq) begin
         idx = pending.size();
         while (idx > 0 && pending[idx-1] > cyl) idx--;
         pending.insert(idx, cyl);
      end
      if (!fin) return;
      split = pending.size();
      for (int i = 0; i < pending.size(); i++)
         if (pending[i] >= head_pos) begin
            split = i;
            break;
         end
      seek = 0;
      pos = head_pos;
      for (int i = split; i < pending.size(); i++)
         add_move(pending[i], KIND_SERVED, abs_diff(pending[i], pos), seek, pos);
      if (pos != top_cyl)
         add_move(top_cyl, KIND_TOP, abs_diff(top_cyl, pos), seek, pos);
      add_move('0, KIND_ZERO, top_cyl, seek, pos);
      for (int i = 0; i < split; i++)
         add_move(pending[i], KIND_SERVED, abs_diff(pending[i], pos), seek, pos);
      m = expected_moves.pop_back();
      m.last = 1'b1;
      expected_moves.push_back(m);
      pending.delete();
   endfunction

   // send one request transaction, with random idle cycles ahead of it
   task automatic send_request(input logic [CylW-1:0] cyl, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.request_cylinder <= cyl;
      req.final_request <= fin;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      plan_sweep(cyl, fin);
   endtask

   // wait until the block is idle again
   task automatic drain();
      req.valid <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (2 * MaxReq + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [CylW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrW'({idx, 2'b00});
      csr_pwdata <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_HEAD) head_pos = value;
      else top_cyl = value;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CylW-1:0] head, input logic [CylW-1:0] top);
      drain();
      write_reg(REG_HEAD, head);
      write_reg(REG_TOP, top);
   endtask

   // directed batches: extremes, head at top, nothing above the head
   task automatic test_directed();
      send_request(16'd50, 1'b0);
      send_request(16'd10, 1'b0);
      send_request(16'd150, 1'b1);
      send_request(16'd0, 1'b1);
      set_geometry(16'd100, 16'd199);
      send_request(16'd20, 1'b0);
      send_request(16'd40, 1'b1);
      set_geometry(16'd199, 16'd199);
      send_request(16'd199, 1'b1);
      set_geometry(16'hFFFF, 16'hFFFF);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'h8000, 1'b1);
      set_geometry(16'h0000, 16'h0000);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h5555, 1'b0);
      send_request(16'hAAAA, 1'b1);
      set_geometry(16'h1000, 16'h0100);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0001, 1'b1);
   endtask

   // fill past the list capacity so the extra requests are dropped
   task automatic test_overflow();
      set_geometry(16'h7FFF, 16'hFFFF);
      for (int i = 0; i < MaxReq + 4; i++)
         send_request(16'($urandom_range(65535)), i == MaxReq + 3);
   endtask

   // random batches under one backpressure profile
   task automatic test_random(input int idle_pct, input int stall_pct, input int items);
      int sent;
      int len;
      drain();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      case ($urandom_range(3))
         0: set_geometry(16'($urandom_range(65535)), 16'($urandom_range(65535)));
         1: set_geometry(16'($urandom_range(300)), 16'd199);
         default: set_geometry(16'($urandom_range(1000)), 16'($urandom_range(1000)));
      endcase
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(MaxReq + 3, 1) : $urandom_range(8, 1);
         for (int i = 0; i < len; i++) begin
            send_request($urandom_range(1) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(1100)), i == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      head_pos = '0;
      top_cyl = TopReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_random(0, 0, 100);
      test_random(80, 0, 90);
      test_random(0, 80, 90);
      test_random(25, 25, 100);
      test_random(0, 0, 60);
      drain();
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
